// ===== rtl/rbrd_pkg.sv =====
package rbrd_pkg;

    localparam int CLUSTER_SIZE = 6;

    localparam int RANGE_W      = 24;
    localparam int ANGLE_W      = 16;
    localparam int CPR_W        = 11;
    localparam int RPS_W        = 9;
    localparam int MAX_CLUSTERS = 1024;
    localparam int MAX_ROWS     = 256;
    localparam int CI_W         = $clog2(MAX_CLUSTERS);
    localparam int RI_W         = $clog2(MAX_ROWS);

    localparam int SIC_W = $clog2(CLUSTER_SIZE);
    localparam int CNT_W = $clog2(CLUSTER_SIZE + 1);
    localparam int SUM_W = RANGE_W + $clog2(CLUSTER_SIZE);
    localparam int DEN_W = CNT_W + 1;
    localparam int NUM_W = SUM_W + 2;

    // divider retires DIV_BITS quotient bits per cycle
    localparam int DIV_BITS = 4;
    localparam int DIV_ITER = (NUM_W + DIV_BITS - 1) / DIV_BITS;
    localparam int NUM_PAD  = DIV_ITER * DIV_BITS;
    localparam int ITER_W   = $clog2(DIV_ITER + 1);

    // azimuth multiplier 2*N*cluster + (N-1)
    localparam int K_MAX = 2 * CLUSTER_SIZE * (MAX_CLUSTERS - 1) + CLUSTER_SIZE - 1;
    localparam int K_W   = $clog2(K_MAX + 1);

    localparam int AZP_W    = ANGLE_W + K_W + 1;
    localparam int AZ_ACC_W = AZP_W + 2;
    localparam int ELP_W    = ANGLE_W + RI_W + 1;

    localparam logic signed [AZ_ACC_W-1:0] SAT_HI = AZ_ACC_W'(2 ** (ANGLE_W - 1) - 1);
    localparam logic signed [AZ_ACC_W-1:0] SAT_LO = -SAT_HI - AZ_ACC_W'(1);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_GATE_LO      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GATE_HI      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_AZ_START     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_AZ_STEP      = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_EL_START     = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_EL_STEP      = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_CLUSTERS_ROW = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_SCAN    = CFG_IDX_W'(7);

    typedef struct packed {
        logic        [RANGE_W-1:0] gate_lo;
        logic        [RANGE_W-1:0] gate_hi;
        logic signed [ANGLE_W-1:0] az_start;
        logic signed [ANGLE_W-1:0] az_step;
        logic signed [ANGLE_W-1:0] el_start;
        logic signed [ANGLE_W-1:0] el_step;
        logic        [CPR_W-1:0]   clusters_per_row;
        logic        [RPS_W-1:0]   rows_per_scan;
    } cfg_t;

    // one finished cluster handed from front to back
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
        logic [K_W-1:0]   k;
        logic [RI_W-1:0]  ri;
        logic             eos;
    } job_t;

    function automatic logic signed [ANGLE_W-1:0] sat_angle(
        input logic signed [AZ_ACC_W-1:0] v
    );
        logic signed [ANGLE_W-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI[ANGLE_W-1:0];
        else if (v < SAT_LO)
            r = SAT_LO[ANGLE_W-1:0];
        else
            r = v[ANGLE_W-1:0];
        return r;
    endfunction

endpackage

// ===== rtl/rbrd_front.sv =====
module rbrd_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rbrd_pkg::cfg_t              cfg,
    input  logic                        push,
    output logic                        full,
    input  logic [rbrd_pkg::RANGE_W-1:0] range_sample,
    input  logic                        q_full,
    output logic                        q_wr,
    output rbrd_pkg::job_t              q_wdata
);

    logic [rbrd_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [rbrd_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic [rbrd_pkg::SIC_W-1:0] sic_reg, sic_next;
    logic [rbrd_pkg::CI_W-1:0]  ci_reg, ci_next;
    logic [rbrd_pkg::RI_W-1:0]  ri_reg, ri_next;

    logic                       accept;
    logic                       in_gate;
    logic                       last_sample;
    logic                       last_cluster;
    logic                       last_row;
    logic [rbrd_pkg::SUM_W-1:0] sum_acc;
    logic [rbrd_pkg::CNT_W-1:0] cnt_acc;
    logic [rbrd_pkg::CPR_W-1:0] ncl;
    logic [rbrd_pkg::RPS_W-1:0] nrw;

    assign full   = q_full;
    assign accept = push && !q_full;

    assign in_gate = (range_sample >= cfg.gate_lo) && (range_sample <= cfg.gate_hi);
    assign sum_acc = in_gate ? sum_reg + rbrd_pkg::SUM_W'(range_sample) : sum_reg;
    assign cnt_acc = in_gate ? cnt_reg + rbrd_pkg::CNT_W'(1) : cnt_reg;

    assign last_sample = sic_reg >= rbrd_pkg::SIC_W'(rbrd_pkg::CLUSTER_SIZE - 1);

    // out-of-range counts clamp to 1..max
    always_comb
    begin
        priority if (cfg.clusters_per_row == '0)
            ncl = rbrd_pkg::CPR_W'(1);
        else if (cfg.clusters_per_row > rbrd_pkg::CPR_W'(rbrd_pkg::MAX_CLUSTERS))
            ncl = rbrd_pkg::CPR_W'(rbrd_pkg::MAX_CLUSTERS);
        else
            ncl = cfg.clusters_per_row;

        priority if (cfg.rows_per_scan == '0)
            nrw = rbrd_pkg::RPS_W'(1);
        else if (cfg.rows_per_scan > rbrd_pkg::RPS_W'(rbrd_pkg::MAX_ROWS))
            nrw = rbrd_pkg::RPS_W'(rbrd_pkg::MAX_ROWS);
        else
            nrw = cfg.rows_per_scan;
    end

    assign last_cluster = (rbrd_pkg::CPR_W'(ci_reg) + rbrd_pkg::CPR_W'(1)) >= ncl;
    assign last_row     = (rbrd_pkg::RPS_W'(ri_reg) + rbrd_pkg::RPS_W'(1)) >= nrw;

    always_comb
    begin
        sum_next = sum_reg;
        cnt_next = cnt_reg;
        sic_next = sic_reg;
        ci_next  = ci_reg;
        ri_next  = ri_reg;
        q_wr     = 1'b0;
        if (accept)
        begin
            if (last_sample)
            begin
                q_wr     = 1'b1;
                sum_next = '0;
                cnt_next = '0;
                sic_next = '0;
                if (last_cluster)
                begin
                    ci_next = '0;
                    ri_next = last_row ? '0 : ri_reg + rbrd_pkg::RI_W'(1);
                end
                else
                begin
                    ci_next = ci_reg + rbrd_pkg::CI_W'(1);
                end
            end
            else
            begin
                sum_next = sum_acc;
                cnt_next = cnt_acc;
                sic_next = sic_reg + rbrd_pkg::SIC_W'(1);
            end
        end
    end

    always_comb
    begin
        q_wdata.sum = sum_acc;
        q_wdata.cnt = cnt_acc;
        q_wdata.k   = rbrd_pkg::K_W'(ci_reg) * rbrd_pkg::K_W'(2 * rbrd_pkg::CLUSTER_SIZE)
                    + rbrd_pkg::K_W'(rbrd_pkg::CLUSTER_SIZE - 1);
        q_wdata.ri  = ri_reg;
        q_wdata.eos = last_cluster && last_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
            sic_reg <= '0;
            ci_reg  <= '0;
            ri_reg  <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            sic_reg <= sic_next;
            ci_reg  <= ci_next;
            ri_reg  <= ri_next;
        end
    end

endmodule

// ===== rtl/rbrd_fifo.sv =====
module rbrd_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr,
    input  rbrd_pkg::job_t wdata,
    output logic           full,
    input  logic           rd,
    output logic           nonempty,
    output rbrd_pkg::job_t rdata
);

    rbrd_pkg::job_t mem [rbrd_pkg::QDEPTH];

    logic [rbrd_pkg::QPTR_W-1:0] wp_reg, wp_next;
    logic [rbrd_pkg::QPTR_W-1:0] rp_reg, rp_next;
    logic [rbrd_pkg::QCNT_W-1:0] count_reg, count_next;

    assign full     = count_reg == rbrd_pkg::QCNT_W'(rbrd_pkg::QDEPTH);
    assign nonempty = count_reg != '0;
    assign rdata    = mem[rp_reg];

    always_comb
    begin
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        count_next = count_reg;
        if (wr)
            wp_next = (wp_reg == rbrd_pkg::QPTR_W'(rbrd_pkg::QDEPTH - 1)) ?
                      '0 : wp_reg + rbrd_pkg::QPTR_W'(1);
        if (rd)
            rp_next = (rp_reg == rbrd_pkg::QPTR_W'(rbrd_pkg::QDEPTH - 1)) ?
                      '0 : rp_reg + rbrd_pkg::QPTR_W'(1);
        if (wr && !rd)
            count_next = count_reg + rbrd_pkg::QCNT_W'(1);
        else if (rd && !wr)
            count_next = count_reg - rbrd_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem[wp_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg    <= '0;
            rp_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            count_reg <= count_next;
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rbrd_pkg::QCNT_W'(rbrd_pkg::QDEPTH))
        else $error("queue count past depth");

    a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr && full && !rd))
        else $error("cluster written into full queue");

endmodule

// ===== rtl/rbrd_back.sv =====
module rbrd_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rbrd_pkg::cfg_t                      cfg,
    input  logic                                q_valid,
    input  rbrd_pkg::job_t                      q_rdata,
    output logic                                q_rd,
    input  logic                                pop,
    output logic                                empty,
    output logic        [rbrd_pkg::RANGE_W-1:0] avg_range,
    output logic signed [rbrd_pkg::ANGLE_W-1:0] avg_azimuth,
    output logic signed [rbrd_pkg::ANGLE_W-1:0] row_elevation,
    output logic                                point_valid,
    output logic                                end_of_scan
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [rbrd_pkg::ITER_W-1:0] iter_reg, iter_next;

    logic [rbrd_pkg::NUM_PAD-1:0] num_reg, num_next;
    logic [rbrd_pkg::NUM_PAD-1:0] quo_reg, quo_next;
    logic [rbrd_pkg::DEN_W-1:0]   rem_reg, rem_next;
    logic [rbrd_pkg::DEN_W-1:0]   den_reg, den_next;
    logic                         nz_reg, nz_next;
    logic                         eos_reg, eos_next;
    logic signed [rbrd_pkg::AZP_W-1:0] azp_reg, azp_next;
    logic signed [rbrd_pkg::ELP_W-1:0] elp_reg, elp_next;

    logic                                out_valid_reg, out_valid_next;
    logic        [rbrd_pkg::RANGE_W-1:0] avg_range_reg, avg_range_next;
    logic signed [rbrd_pkg::ANGLE_W-1:0] az_reg, az_next;
    logic signed [rbrd_pkg::ANGLE_W-1:0] el_reg, el_next;
    logic                                pv_reg, pv_next;
    logic                                eos_out_reg, eos_out_next;

    logic [rbrd_pkg::NUM_PAD-1:0] dv_num;
    logic [rbrd_pkg::NUM_PAD-1:0] dv_quo;
    logic [rbrd_pkg::DEN_W-1:0]   dv_rem;
    logic [rbrd_pkg::DEN_W:0]     dv_t;

    logic signed [rbrd_pkg::AZ_ACC_W-1:0] az_twice;
    logic signed [rbrd_pkg::AZ_ACC_W-1:0] az_half;
    logic signed [rbrd_pkg::AZ_ACC_W-1:0] el_sum;
    logic                                 out_free;

    assign empty         = !out_valid_reg;
    assign avg_range     = avg_range_reg;
    assign avg_azimuth   = az_reg;
    assign row_elevation = el_reg;
    assign point_valid   = pv_reg;
    assign end_of_scan   = eos_out_reg;

    assign out_free = !out_valid_reg || pop;

    // restoring divide, DIV_BITS quotient bits per cycle
    always_comb
    begin
        dv_num = num_reg;
        dv_quo = quo_reg;
        dv_rem = rem_reg;
        dv_t   = '0;
        for (int j = 0; j < rbrd_pkg::DIV_BITS; j++)
        begin
            dv_t   = {dv_rem, dv_num[rbrd_pkg::NUM_PAD-1]};
            dv_num = {dv_num[rbrd_pkg::NUM_PAD-2:0], 1'b0};
            if (dv_t >= {1'b0, den_reg})
            begin
                dv_t   = dv_t - {1'b0, den_reg};
                dv_quo = {dv_quo[rbrd_pkg::NUM_PAD-2:0], 1'b1};
            end
            else
            begin
                dv_quo = {dv_quo[rbrd_pkg::NUM_PAD-2:0], 1'b0};
            end
            dv_rem = dv_t[rbrd_pkg::DEN_W-1:0];
        end
    end

    // round-half-up of the exact mean azimuth, then saturate
    always_comb
    begin
        az_twice = (rbrd_pkg::AZ_ACC_W'(cfg.az_start) <<< 1)
                 + rbrd_pkg::AZ_ACC_W'(azp_reg) + rbrd_pkg::AZ_ACC_W'(1);
        az_half  = az_twice >>> 1;
        el_sum   = rbrd_pkg::AZ_ACC_W'(cfg.el_start) + rbrd_pkg::AZ_ACC_W'(elp_reg);
    end

    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        num_next       = num_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        nz_next        = nz_reg;
        eos_next       = eos_reg;
        azp_next       = azp_reg;
        elp_next       = elp_reg;
        out_valid_next = out_valid_reg && !pop;
        avg_range_next = avg_range_reg;
        az_next        = az_reg;
        el_next        = el_reg;
        pv_next        = pv_reg;
        eos_out_next   = eos_out_reg;
        q_rd           = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_rd       = 1'b1;
                    num_next   = rbrd_pkg::NUM_PAD'({q_rdata.sum, 1'b0})
                               + rbrd_pkg::NUM_PAD'(q_rdata.cnt);
                    den_next   = {q_rdata.cnt, 1'b0};
                    quo_next   = '0;
                    rem_next   = '0;
                    nz_next    = q_rdata.cnt != '0;
                    eos_next   = q_rdata.eos;
                    azp_next   = rbrd_pkg::AZP_W'(cfg.az_step)
                               * rbrd_pkg::AZP_W'($signed({1'b0, q_rdata.k}));
                    elp_next   = rbrd_pkg::ELP_W'(cfg.el_step)
                               * rbrd_pkg::ELP_W'($signed({1'b0, q_rdata.ri}));
                    iter_next  = rbrd_pkg::ITER_W'(rbrd_pkg::DIV_ITER);
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                num_next  = dv_num;
                quo_next  = dv_quo;
                rem_next  = dv_rem;
                iter_next = iter_reg - rbrd_pkg::ITER_W'(1);
                if (iter_reg == rbrd_pkg::ITER_W'(1))
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    avg_range_next = nz_reg ? quo_reg[rbrd_pkg::RANGE_W-1:0] : '0;
                    az_next        = rbrd_pkg::sat_angle(az_half);
                    el_next        = rbrd_pkg::sat_angle(el_sum);
                    pv_next        = nz_reg;
                    eos_out_next   = eos_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        num_reg       <= num_next;
        quo_reg       <= quo_next;
        rem_reg       <= rem_next;
        den_reg       <= den_next;
        nz_reg        <= nz_next;
        eos_reg       <= eos_next;
        azp_reg       <= azp_next;
        elp_reg       <= elp_next;
        avg_range_reg <= avg_range_next;
        az_reg        <= az_next;
        el_reg        <= el_next;
        pv_reg        <= pv_next;
        eos_out_reg   <= eos_out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_rd_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_rd |-> (state_reg == ST_IDLE) && q_valid)
        else $error("queue read outside idle");

    a_div_iter_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (iter_reg != '0) &&
                                  (iter_reg <= rbrd_pkg::ITER_W'(rbrd_pkg::DIV_ITER)))
        else $error("divider iteration count out of range");

    a_hold_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD) && out_free |=> !empty && (state_reg == ST_IDLE))
        else $error("finished cluster not moved to result register");

endmodule

// ===== rtl/radar_beam_range_decimator_core.sv =====
// Gated boxcar range decimator: range samples enter in scan order, one per cycle
// while full is low, and every six samples produce one point (mean in-gate range,
// mean azimuth, row elevation, valid flag, end-of-scan mark). The front end takes a
// sample every cycle while full is low. The back end loads a cluster and multiplies
// the angles, runs the radix-16 iterative range divider, then rounds, saturates and
// writes the result register once it is free; it takes no new cluster until the
// last one is written. A two-entry cluster queue between the two ends absorbs
// bursts, and the result register lets the next cluster be divided while a point
// waits to be popped. Configuration is written via cfg_valid/cfg_ready (always
// ready); write only while idle. No clearing pass.
module radar_beam_range_decimator_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic        [rbrd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [rbrd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                                  push,
    output logic                                  full,
    input  logic        [rbrd_pkg::RANGE_W-1:0]    range_sample,
    output logic                                  empty,
    input  logic                                  pop,
    output logic        [rbrd_pkg::RANGE_W-1:0]    avg_range,
    output logic signed [rbrd_pkg::ANGLE_W-1:0]    avg_azimuth,
    output logic signed [rbrd_pkg::ANGLE_W-1:0]    row_elevation,
    output logic                                  point_valid,
    output logic                                  end_of_scan
);

    rbrd_pkg::cfg_t cfg_reg, cfg_next;

    logic           q_full;
    logic           q_wr;
    logic           q_rd;
    logic           q_valid;
    rbrd_pkg::job_t q_wdata;
    rbrd_pkg::job_t q_rdata;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                rbrd_pkg::REG_GATE_LO:
                    cfg_next.gate_lo = cfg_data[rbrd_pkg::RANGE_W-1:0];
                rbrd_pkg::REG_GATE_HI:
                    cfg_next.gate_hi = cfg_data[rbrd_pkg::RANGE_W-1:0];
                rbrd_pkg::REG_AZ_START:
                    cfg_next.az_start = cfg_data[rbrd_pkg::ANGLE_W-1:0];
                rbrd_pkg::REG_AZ_STEP:
                    cfg_next.az_step = cfg_data[rbrd_pkg::ANGLE_W-1:0];
                rbrd_pkg::REG_EL_START:
                    cfg_next.el_start = cfg_data[rbrd_pkg::ANGLE_W-1:0];
                rbrd_pkg::REG_EL_STEP:
                    cfg_next.el_step = cfg_data[rbrd_pkg::ANGLE_W-1:0];
                rbrd_pkg::REG_CLUSTERS_ROW:
                    cfg_next.clusters_per_row = cfg_data[rbrd_pkg::CPR_W-1:0];
                rbrd_pkg::REG_ROWS_SCAN:
                    cfg_next.rows_per_scan = cfg_data[rbrd_pkg::RPS_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gate_lo          <= '0;
            cfg_reg.gate_hi          <= '1;
            cfg_reg.az_start         <= '0;
            cfg_reg.az_step          <= '0;
            cfg_reg.el_start         <= '0;
            cfg_reg.el_step          <= '0;
            cfg_reg.clusters_per_row <= rbrd_pkg::CPR_W'(1);
            cfg_reg.rows_per_scan    <= rbrd_pkg::RPS_W'(1);
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    rbrd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .push         (push),
        .full         (full),
        .range_sample (range_sample),
        .q_full       (q_full),
        .q_wr         (q_wr),
        .q_wdata      (q_wdata)
    );

    rbrd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (q_wr),
        .wdata    (q_wdata),
        .full     (q_full),
        .rd       (q_rd),
        .nonempty (q_valid),
        .rdata    (q_rdata)
    );

    rbrd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_rdata       (q_rdata),
        .q_rd          (q_rd),
        .pop           (pop),
        .empty         (empty),
        .avg_range     (avg_range),
        .avg_azimuth   (avg_azimuth),
        .row_elevation (row_elevation),
        .point_valid   (point_valid),
        .end_of_scan   (end_of_scan)
    );

endmodule
